>>> sv/rrtq_pkg.sv
// Shared types and constants for the round-robin thread queue.
// Holds the request and result structures, operation and status codes.
// No dependencies; the other files, rrtq_ram apart, refer to it by scoped names.
package rrtq_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;

    // Fixed widths of the interface fields.
    localparam int TID_W    = 16;
    localparam int QLEN_W   = 5;
    localparam int STATUS_W = 2;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_ADMIT    = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_NEXT     = 2'd2,
        OP_SHUTDOWN = 2'd3
    } t_op;

    // Status codes returned with every result.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

    // One request as it enters the block.
    typedef struct packed {
        t_op              op;
        logic [TID_W-1:0] thread_id;
    } t_request;

    // One result as it leaves the block.
    typedef struct packed {
        logic [TID_W-1:0]    chosen_thread;
        logic                chosen_valid;
        logic [QLEN_W-1:0]   queue_length;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

>>> sv/round_robin_thread_queue.sv
// Round-robin thread queue: sequencer around the slot memory.
// Depends on rrtq_pkg and rrtq_ram.
//
// A request is taken when start is high and busy is low; its result appears
// on o_result for exactly one cycle with o_done high and cannot be held off.
// Admit, shutdown, and next or remove on an empty queue give their result in
// the cycle after the request and leave busy low, so such requests may follow
// each other every cycle. Next keeps busy high while the chosen slot is read
// through the registered read port of the slot memory. Remove streams every
// stored slot once through that single read port, compares each against the
// id, and writes every slot after the match back one place lower as it
// passes. The slot memory needs no clearing after reset; only slots below the
// entry count are ever read.
module round_robin_thread_queue #(
    parameter int QUEUE_DEPTH = rrtq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = rrtq_pkg::DEF_ID_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rrtq_pkg::t_request i_request,
    output logic               o_done,
    output rrtq_pkg::t_result  o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_NEXT
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_cur;
    logic                  r_cv;
    logic [ID_WIDTH-1:0]   r_id;
    logic [CW-1:0]         r_rd_ptr;
    logic                  r_dt_vld;
    logic [AW-1:0]         r_dt_idx;
    logic                  r_found;
    logic [AW-1:0]         r_pos;

    logic                  w_accept;
    logic [ID_WIDTH-1:0]   w_id;
    logic [AW-1:0]         w_next_cur;
    logic                  w_admit_ok;
    logic                  w_next_rd;
    logic                  w_rd_scan;
    logic                  w_shift_wr;
    logic                  w_hit;
    logic                  w_last;
    logic                  w_found;
    logic [AW-1:0]         w_pos;
    logic [CW-1:0]         n_count_rm;
    logic [AW-1:0]         n_cur_rm;
    logic                  n_cv_rm;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [ID_WIDTH-1:0]   w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [ID_WIDTH-1:0]   w_rd_data;

    // Handshake and request decode.
    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_id       = ID_WIDTH'(i_request.thread_id);
    assign w_admit_ok = w_accept && (i_request.op == rrtq_pkg::OP_ADMIT)
                        && (r_count != FULL_COUNT);
    assign w_next_rd  = w_accept && (i_request.op == rrtq_pkg::OP_NEXT)
                        && (r_count != '0);

    // Cursor advance for next: head when there is no cursor or after the tail.
    always_comb begin
        if (!r_cv || ((CW'(r_cur) + CW'(1)) >= r_count)) begin
            w_next_cur = '0;
        end else begin
            w_next_cur = r_cur + AW'(1);
        end
    end

    // Remove scan: one slot read per cycle, compare, and shift later slots down.
    assign w_rd_scan  = (r_state == S_SCAN) && (r_rd_ptr < r_count);
    assign w_hit      = r_dt_vld && !r_found && (w_rd_data == r_id);
    assign w_shift_wr = (r_state == S_SCAN) && r_dt_vld && r_found;
    assign w_last     = (r_state == S_SCAN) && r_dt_vld
                        && (CW'(r_dt_idx) == (r_count - CW'(1)));
    assign w_found    = r_found || w_hit;
    assign w_pos      = r_found ? r_pos : r_dt_idx;

    // Count and cursor after a successful remove.
    always_comb begin
        n_count_rm = r_count - CW'(1);
        n_cur_rm   = r_cur;
        n_cv_rm    = r_cv;
        if (r_cv && (w_pos <= r_cur)) begin
            if (r_cur == '0) begin
                n_cv_rm = 1'b0;
            end else begin
                n_cur_rm = r_cur - AW'(1);
            end
        end
        if (n_count_rm == '0) begin
            n_cv_rm  = 1'b0;
            n_cur_rm = '0;
        end
    end

    // Memory port selection.
    assign w_wr_en   = w_admit_ok || w_shift_wr;
    assign w_wr_addr = w_shift_wr ? (r_dt_idx - AW'(1)) : r_count[AW-1:0];
    assign w_wr_data = w_shift_wr ? w_rd_data : w_id;
    assign w_rd_en   = w_next_rd || w_rd_scan;
    assign w_rd_addr = (r_state == S_SCAN) ? r_rd_ptr[AW-1:0] : w_next_cur;

    rrtq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer state, queue state and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cur    <= '0;
            r_cv     <= 1'b0;
            r_rd_ptr <= '0;
            r_dt_vld <= 1'b0;
            r_found  <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        o_result              <= '0;
                        o_result.queue_length <= rrtq_pkg::QLEN_W'(r_count);
                        unique case (i_request.op)
                            rrtq_pkg::OP_ADMIT: begin
                                o_done <= 1'b1;
                                if (r_count == FULL_COUNT) begin
                                    o_result.status <= rrtq_pkg::ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    o_result.queue_length <=
                                        rrtq_pkg::QLEN_W'(r_count + CW'(1));
                                end
                            end
                            rrtq_pkg::OP_REMOVE: begin
                                if (r_count == '0) begin
                                    o_done          <= 1'b1;
                                    o_result.status <= rrtq_pkg::ST_NO_MATCH;
                                end else begin
                                    r_state  <= S_SCAN;
                                    r_id     <= w_id;
                                    r_rd_ptr <= '0;
                                    r_dt_vld <= 1'b0;
                                    r_found  <= 1'b0;
                                end
                            end
                            rrtq_pkg::OP_NEXT: begin
                                if (r_count == '0) begin
                                    o_done <= 1'b1;
                                    r_cv   <= 1'b0;
                                    r_cur  <= '0;
                                end else begin
                                    r_cur   <= w_next_cur;
                                    r_cv    <= 1'b1;
                                    r_state <= S_NEXT;
                                end
                            end
                            rrtq_pkg::OP_SHUTDOWN: begin
                                o_done                <= 1'b1;
                                r_count               <= '0;
                                r_cv                  <= 1'b0;
                                r_cur                 <= '0;
                                o_result.queue_length <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_dt_vld <= w_rd_scan;
                    r_dt_idx <= r_rd_ptr[AW-1:0];
                    if (w_rd_scan) begin
                        r_rd_ptr <= r_rd_ptr + CW'(1);
                    end
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_pos   <= r_dt_idx;
                    end
                    if (w_last) begin
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                        r_dt_vld <= 1'b0;
                        o_result <= '0;
                        if (w_found) begin
                            r_count <= n_count_rm;
                            r_cur   <= n_cur_rm;
                            r_cv    <= n_cv_rm;
                            o_result.queue_length <= rrtq_pkg::QLEN_W'(n_count_rm);
                        end else begin
                            o_result.status       <= rrtq_pkg::ST_NO_MATCH;
                            o_result.queue_length <= rrtq_pkg::QLEN_W'(r_count);
                        end
                    end
                end
                S_NEXT: begin
                    o_done                 <= 1'b1;
                    r_state                <= S_IDLE;
                    o_result.chosen_thread <= rrtq_pkg::TID_W'(w_rd_data);
                    o_result.chosen_valid  <= 1'b1;
                    o_result.queue_length  <= rrtq_pkg::QLEN_W'(r_count);
                    o_result.status        <= rrtq_pkg::ST_OK;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The entry count never goes past the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count exceeds queue depth");

    // A valid cursor always points at a stored entry.
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (CW'(r_cur) < r_count))
        else $error("cursor points past the tail");

    // An accepted request either completes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_done || busy))
        else $error("request accepted but neither completed nor in progress");

    // A picked thread is only ever reported with an ok status.
    a_chosen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.chosen_valid) |-> (o_result.status == rrtq_pkg::ST_OK))
        else $error("chosen thread reported with an error status");

    // The shift write never comes from the head slot, so the slot below it exists.
    a_shift_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift_wr |-> (r_dt_idx != '0))
        else $error("gap-closing write below the head");
`endif

endmodule

>>> sv/rrtq_ram.sv
// Slot memory for the round-robin thread queue.
// One write port and one read port, read data registered.
// No package dependencies.
module rrtq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> tb/rrtq_checker.sv
// Result checker for the round-robin thread queue testbench.
// Watches the request and result channels, predicts each result and compares it.
// Depends on rrtq_pkg for the request and result structures and their codes.
module rrtq_checker #(
    parameter int QUEUE_DEPTH = rrtq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  rrtq_pkg::t_request i_request,
    input  logic               i_done,
    input  rrtq_pkg::t_result  i_result,
    output int                 o_pending,
    output int                 o_fail_count,
    output int                 o_result_count,
    output int                 o_full_count,
    output int                 o_miss_count
);

    localparam int SW = $clog2(QUEUE_DEPTH);

    // Shadow copy of the run queue and its cursor.
    logic [rrtq_pkg::TID_W-1:0] shadow_slots [QUEUE_DEPTH];
    int                         shadow_count = 0;
    int                         shadow_cursor = 0;
    logic                       shadow_cursor_vld = 1'b0;

    // Results still owed by the block, oldest first.
    rrtq_pkg::t_result expected_results [$];

    // Applies one request to the shadow queue and returns the result it should give.
    task automatic schedule_request(input rrtq_pkg::t_request req,
                                    output rrtq_pkg::t_result res);
        int match_pos;
        int k;
        begin
            res = '0;
            res.status = rrtq_pkg::ST_OK;
            case (req.op)
                rrtq_pkg::OP_ADMIT: begin
                    if (shadow_count >= QUEUE_DEPTH) begin
                        res.status = rrtq_pkg::ST_FULL;
                        o_full_count++;
                    end else begin
                        shadow_slots[SW'(shadow_count)] = req.thread_id;
                        shadow_count++;
                    end
                end
                rrtq_pkg::OP_REMOVE: begin
                    // The first matching entry goes; later entries close the gap.
                    match_pos = shadow_count;
                    for (k = 0; k < shadow_count; k++) begin
                        if (match_pos == shadow_count
                            && shadow_slots[SW'(k)] == req.thread_id) begin
                            match_pos = k;
                        end
                    end
                    if (match_pos >= shadow_count) begin
                        res.status = rrtq_pkg::ST_NO_MATCH;
                        o_miss_count++;
                    end else begin
                        for (k = match_pos; k + 1 < shadow_count; k++) begin
                            shadow_slots[SW'(k)] = shadow_slots[SW'(k + 1)];
                        end
                        shadow_count--;
                        // Keep cursor on the same thread; if removed, step back or drop at head.
                        if (shadow_cursor_vld && match_pos <= shadow_cursor) begin
                            if (shadow_cursor == 0) begin
                                shadow_cursor_vld = 1'b0;
                            end else begin
                                shadow_cursor--;
                            end
                        end
                        if (shadow_count == 0) begin
                            shadow_cursor_vld = 1'b0;
                            shadow_cursor     = 0;
                        end
                    end
                end
                rrtq_pkg::OP_NEXT: begin
                    if (shadow_count == 0) begin
                        shadow_cursor_vld = 1'b0;
                        shadow_cursor     = 0;
                    end else begin
                        // Start at the head when there is no cursor, and wrap after the tail.
                        if (!shadow_cursor_vld || shadow_cursor + 1 >= shadow_count) begin
                            shadow_cursor = 0;
                        end else begin
                            shadow_cursor++;
                        end
                        shadow_cursor_vld = 1'b1;
                        res.chosen_thread = shadow_slots[SW'(shadow_cursor)];
                        res.chosen_valid  = 1'b1;
                    end
                end
                default: begin
                    shadow_count      = 0;
                    shadow_cursor_vld = 1'b0;
                    shadow_cursor     = 0;
                end
            endcase
            res.queue_length = shadow_count[rrtq_pkg::QLEN_W-1:0];
        end
    endtask

    // Results are compared before a new request is predicted, since a result
    // taken at an edge always belongs to an earlier request.
    always @(posedge i_clk) begin : watch
        rrtq_pkg::t_result want;
        if (!i_rst_n) begin
            shadow_count      = 0;
            shadow_cursor     = 0;
            shadow_cursor_vld = 1'b0;
            o_fail_count      = 0;
            o_result_count    = 0;
            o_full_count      = 0;
            o_miss_count      = 0;
        end else begin
            if (i_done) begin
                o_result_count++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result %h arrived with no request outstanding",
                             $time, i_result);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.chosen_thread !== want.chosen_thread) begin
                        $display("%0t: chosen_thread expected %h, got %h",
                                 $time, want.chosen_thread, i_result.chosen_thread);
                        o_fail_count++;
                    end
                    if (i_result.chosen_valid !== want.chosen_valid) begin
                        $display("%0t: chosen_valid expected %b, got %b",
                                 $time, want.chosen_valid, i_result.chosen_valid);
                        o_fail_count++;
                    end
                    if (i_result.queue_length !== want.queue_length) begin
                        $display("%0t: queue_length expected %0d, got %0d",
                                 $time, want.queue_length, i_result.queue_length);
                        o_fail_count++;
                    end
                    if (i_result.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_result.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                schedule_request(i_request, want);
                expected_results.push_back(want);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> tb/round_robin_thread_queue_tb.sv
// Testbench top for the round-robin thread queue: clock, reset, request stimulus, verdict.
// Depends on rrtq_pkg, round_robin_thread_queue and the rrtq_checker module.
module round_robin_thread_queue_tb;

    localparam int QUEUE_DEPTH    = rrtq_pkg::DEF_QUEUE_DEPTH;
    localparam int TOTAL_REQUESTS = 650;
    localparam int IDLE_LIMIT     = 2000;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               start     = 1'b0;
    rrtq_pkg::t_request i_request = '0;
    logic               busy;
    logic               o_done;
    rrtq_pkg::t_result  o_result;

    int pending;
    int fail_count;
    int result_count;
    int full_count;
    int miss_count;
    int op_count [4];
    int issued      = 0;
    int idle_cycles = 0;

    logic [rrtq_pkg::TID_W-1:0] id_pool [8];

    round_robin_thread_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_WIDTH   (rrtq_pkg::DEF_ID_WIDTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_request(i_request),
        .o_done   (o_done),
        .o_result (o_result)
    );

    rrtq_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_request     (i_request),
        .i_done        (o_done),
        .i_result      (o_result),
        .o_pending     (pending),
        .o_fail_count  (fail_count),
        .o_result_count(result_count),
        .o_full_count  (full_count),
        .o_miss_count  (miss_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: give up when neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or result for %0d cycles", $time, IDLE_LIMIT);
            $display("round_robin_thread_queue_tb failed");
            $finish;
        end
    end

    // Mostly ids from a small pool, so that removes often find a match.
    function automatic logic [rrtq_pkg::TID_W-1:0] pick_thread_id();
        if ($urandom_range(0, 4) == 0) begin
            return rrtq_pkg::TID_W'($urandom);
        end
        return id_pool[3'($urandom_range(0, 7))];
    endfunction

    // Presents one request, after an optional gap, and waits until it is taken.
    task automatic issue_request(input rrtq_pkg::t_op op,
                                 input logic [rrtq_pkg::TID_W-1:0] tid,
                                 input bit no_gap);
        rrtq_pkg::t_request req;
        int                 gap;
        begin
            req.op        = op;
            req.thread_id = tid;
            gap = no_gap ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            start     <= 1'b1;
            i_request <= req;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            op_count[op]++;
            issued++;
        end
    endtask

    // Holds requests back until every outstanding result has come out.
    task automatic wait_for_results();
        begin
            start <= 1'b0;
            do @(posedge i_clk); while (pending != 0);
        end
    endtask

    initial begin : stimulus
        int            mode;
        int            len;
        int            k;
        int            pick;
        bit            tight;
        bit            first_block;
        rrtq_pkg::t_op op;

        for (k = 0; k < 8; k++) begin
            id_pool[3'(k)] = rrtq_pkg::TID_W'($urandom);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty queue, extreme ids, duplicates, cursor movement and wrap,
        // removes before, on and after the cursor, and shutdown.
        issue_request(rrtq_pkg::OP_REMOVE, 16'h1234, 1'b0);   // no match on an empty queue
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b0);     // nothing to pick
        issue_request(rrtq_pkg::OP_ADMIT, 16'h0000, 1'b0);
        issue_request(rrtq_pkg::OP_ADMIT, 16'hFFFF, 1'b0);
        issue_request(rrtq_pkg::OP_ADMIT, 16'hFFFF, 1'b0);    // duplicate id is stored again
        issue_request(rrtq_pkg::OP_NEXT, 16'hFFFF, 1'b0);     // no cursor yet, so the head
        issue_request(rrtq_pkg::OP_REMOVE, 16'h0000, 1'b0);   // cursor on the head goes invalid
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b0);
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b0);
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b0);     // wraps to the head
        issue_request(rrtq_pkg::OP_ADMIT, 16'hA5A5, 1'b1);
        issue_request(rrtq_pkg::OP_ADMIT, 16'h5A5A, 1'b1);
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b1);
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b1);
        issue_request(rrtq_pkg::OP_REMOVE, 16'hFFFF, 1'b0);   // entry before the cursor
        issue_request(rrtq_pkg::OP_REMOVE, 16'hA5A5, 1'b0);   // the cursor entry itself
        issue_request(rrtq_pkg::OP_REMOVE, 16'h5A5A, 1'b0);   // entry after the cursor
        issue_request(rrtq_pkg::OP_REMOVE, 16'h7777, 1'b0);   // no match on a non-empty queue
        issue_request(rrtq_pkg::OP_REMOVE, 16'hFFFF, 1'b0);   // empties the queue
        issue_request(rrtq_pkg::OP_ADMIT, 16'h8001, 1'b0);
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b0);
        issue_request(rrtq_pkg::OP_SHUTDOWN, 16'hFFFF, 1'b0);
        issue_request(rrtq_pkg::OP_NEXT, 16'h0000, 1'b0);

        // Random part in blocks: filling bursts, draining bursts, single shutdowns and mixed traffic.
        first_block = 1'b1;
        while (issued < TOTAL_REQUESTS) begin
            mode  = first_block ? 0 : $urandom_range(0, 9);
            tight = ($urandom_range(0, 3) == 0);
            if (first_block || $urandom_range(0, 4) == 0) begin
                wait_for_results();
            end
            case (mode)
                0, 1:    len = first_block ? QUEUE_DEPTH + 4 : $urandom_range(10, 20);
                2, 3:    len = $urandom_range(6, 16);
                9:       len = 1;
                default: len = 20;
            endcase
            for (k = 0; k < len; k++) begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0, 1: op = rrtq_pkg::OP_ADMIT;
                    2, 3: op = (pick < 70) ? rrtq_pkg::OP_REMOVE : rrtq_pkg::OP_NEXT;
                    9:    op = rrtq_pkg::OP_SHUTDOWN;
                    default: begin
                        if (pick < 38) begin
                            op = rrtq_pkg::OP_ADMIT;
                        end else if (pick < 63) begin
                            op = rrtq_pkg::OP_REMOVE;
                        end else if (pick < 96) begin
                            op = rrtq_pkg::OP_NEXT;
                        end else begin
                            op = rrtq_pkg::OP_SHUTDOWN;
                        end
                    end
                endcase
                issue_request(op, pick_thread_id(), tight);
            end
            first_block = 1'b0;
        end

        // Let the last results come out, then allow for a late stray one.
        wait_for_results();
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);

        $display("Issued %0d requests: %0d admit, %0d remove, %0d next, %0d shutdown.",
                 issued, op_count[rrtq_pkg::OP_ADMIT], op_count[rrtq_pkg::OP_REMOVE],
                 op_count[rrtq_pkg::OP_NEXT], op_count[rrtq_pkg::OP_SHUTDOWN]);
        $display("Checked %0d results, %0d admits refused as full, %0d removes unmatched.",
                 result_count, full_count, miss_count);
        if (fail_count == 0) begin
            $display("round_robin_thread_queue_tb passed");
        end else begin
            $display("round_robin_thread_queue_tb failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rrtq_pkg.sv
sv/rrtq_ram.sv
sv/round_robin_thread_queue.sv
tb/rrtq_checker.sv
tb/round_robin_thread_queue_tb.sv
